[rtl/core/sorted_priority_queue_unit_defines.svh]
// Assertion macros for the sorted priority queue unit.
// No dependencies; taken in by the top level with `include.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
// Shared types and constants of the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_unit.
`default_nettype none

package spq_pkg;

   localparam int CAPACITY   = 64;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int ID_W       = 16;
   localparam int PRIO_W     = 32;
   localparam int HELD_W     = 7;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SERVE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // One stored entry of a cell.
   typedef struct packed {
      logic                     valid;
      logic signed [PRIO_W-1:0] prio;
      logic [ID_W-1:0]          id;
   } spq_entry_type;

   // Command broadcast to every cell for one beat.
   typedef struct packed {
      logic                     insert;
      logic                     serve;
      logic signed [PRIO_W-1:0] prio;
      logic [ID_W-1:0]          id;
   } spq_cmd_type;

endpackage

`default_nettype wire

[rtl/core/spq_cell.sv]
// One cell of the sorted queue row: holds one entry, compares it with the
// broadcast insert and takes data from its left or right neighbor. Uses spq_pkg.
`default_nettype none

module spq_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire spq_pkg::spq_cmd_type   cmd,
   input  wire logic                  head_hit,
   input  wire logic                  tie_ok,
   input  wire logic                  left_hit,
   input  wire spq_pkg::spq_entry_type left_entry,
   input  wire spq_pkg::spq_entry_type right_entry,
   output spq_pkg::spq_entry_type      entry,
   output logic                        hit
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // The new entry lands at or before this cell.
   always_comb begin
      hit = head_hit || !entry_ff.valid || (cmd.prio > entry_ff.prio) ||
            (tie_ok && (cmd.prio == entry_ff.prio));
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (hit && !left_hit) begin
            entry_in.valid = 1'b1;
            entry_in.prio  = cmd.prio;
            entry_in.id    = cmd.id;
         end else if (hit) begin
            entry_in = left_entry;
         end
      end else if (cmd.serve) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[rtl/core/sorted_priority_queue_unit.sv]
// A request beat is answered from a register in the cycle after it is accepted.
// Throughput: one request per cycle while results drain; every cell compares
// against the broadcast request at once; shifting cells move one place. The input stalls
// only while an unaccepted result sits in the output register.
// Reset (synchronous, active high) empties the queue: count and cell valid
// bits clear; stored priorities and ids are left as they are.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_unit_defines.svh.
`default_nettype none

module sorted_priority_queue_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [spq_pkg::ID_W-1:0]    req_item_id,
   input  wire logic signed [spq_pkg::PRIO_W-1:0] req_priority_req,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [spq_pkg::ID_W-1:0]         rsp_served_id,
   output logic [1:0]                       rsp_status,
   output logic [spq_pkg::HELD_W-1:0]       rsp_entries_held
);
   import spq_pkg::*;

   `include "sorted_priority_queue_unit_defines.svh"

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   spq_cmd_type          cmd;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [ID_W-1:0]      served_id_ff;
   logic [ID_W-1:0]      served_id_in;
   spq_status_type       status_ff;
   spq_status_type       status_in;
   logic [HELD_W-1:0]    held_ff;
   logic [HELD_W-1:0]    held_in;

   spq_entry_type        ent [CAPACITY];
   logic                 hit [CAPACITY];
   logic [CAPACITY-1:0]  valid_vec;

   logic                 packed_ok;
   logic                 count_ok;
   logic                 head_ok;
   logic                 done_ok;

   // Take a new beat whenever the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);

   // Broadcast command: drop inserts into a full queue and serves of an
   // empty one, so the cells only ever see legal moves.
   always_comb begin
      cmd.insert = accept && (req_type == OP_INSERT) && !is_full;
      cmd.serve  = accept && (req_type == OP_SERVE) && !is_empty;
      cmd.prio   = req_priority_req;
      cmd.id     = req_item_id;
   end

   // Cell row, head at index 0. Cell 0 alone decides whether the new entry
   // goes to the head; its hit is broadcast so later cells fall in line.
   // Later cells accept ties, so an entry equal to one behind the head goes
   // in front of it, while a tie with the head goes behind the head.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      spq_entry_type left_e;
      spq_entry_type right_e;

      if (k == 0) begin : g_left_head
         assign left_e = '0;
      end else begin : g_left_body
         assign left_e = ent[k-1];
      end

      if (k == CAPACITY - 1) begin : g_right_tail
         assign right_e = '0;
      end else begin : g_right_body
         assign right_e = ent[k+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .head_hit    ((k == 0) ? 1'b0 : hit[0]),
         .tie_ok      ((k == 0) ? 1'b0 : 1'b1),
         .left_hit    ((k == 0) ? 1'b0 : hit[(k == 0) ? 0 : k-1]),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (ent[k]),
         .hit         (hit[k])
      );

      assign valid_vec[k] = ent[k].valid;
   end

   // Occupancy count and the response for this beat.
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      served_id_in = served_id_ff;
      status_in    = status_ff;
      held_in      = held_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         served_id_in = '0;
         status_in    = STATUS_DONE;
         if (cmd.insert) begin
            count_in = count_ff + CNT_W'(1);
         end else if (cmd.serve) begin
            count_in     = count_ff - CNT_W'(1);
            served_id_in = ent[0].id;
         end else if (req_type == OP_INSERT) begin
            status_in = STATUS_FULL;
         end else begin
            status_in = STATUS_EMPTY;
         end
         held_in = HELD_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload until drained; no reset needed.
   always_ff @(posedge clock) begin
      served_id_ff <= served_id_in;
      status_ff    <= status_in;
      held_ff      <= held_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_served_id    = served_id_ff;
   assign rsp_status       = status_ff;
   assign rsp_entries_held = held_ff;

   assign packed_ok = (((valid_vec >> 1) & ~valid_vec) == '0);
   assign count_ok  = (CNT_W'($countones(valid_vec)) == count_ff);
   assign head_ok   = (ent[0].prio >= ent[1].prio);
   assign done_ok   = rsp_valid && (status_ff == STATUS_DONE);

   // Occupied cells form an unbroken run from the head.
   `SPQ_ASSERT_NOW(a_valid_packed, clock, reset, 1'b1, packed_ok, "cell valid bits not packed")
   // Count matches the number of occupied cells.
   `SPQ_ASSERT_NOW(a_count_match, clock, reset, 1'b1, count_ok, "count disagrees with cells")
   // Head never ranks below the second entry.
   `SPQ_ASSERT_NOW(a_head_order, clock, reset, ent[1].valid, head_ok, "head out of order")
   // A serve of a non-empty queue completes without error.
   `SPQ_ASSERT_NEXT(a_serve_done, clock, reset, cmd.serve, done_ok, "serve not reported done")

endmodule

`default_nettype wire
